// ----- hdl/bu2x_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bu2x_pkg: shared types and constants of the 2x bilinear upscaler
// Holds the request handed from the line-buffer stage to the emitter, the
// position codes of the 3x3 output neighborhood and the mean helper.
// ----------------------------------------------------------------------------
package bu2x_pkg;

  localparam int unsigned CNT_W   = 9;   // source row / column index width
  localparam int unsigned CHAN_W  = 10;  // channel index width
  localparam int unsigned COORD_W = 10;  // output row / column width
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned OUT_DATA_W = 40; // 38 payload bits, padded to bytes

  // Position of an output pixel relative to 2*source (offset -1, 0, +1)
  localparam logic [1:0] POS_LO  = 2'd0;
  localparam logic [1:0] POS_MID = 2'd1;
  localparam logic [1:0] POS_HI  = 2'd2;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SRC_WIDTH    = 2'd0,
    CFG_SRC_HEIGHT   = 2'd1,
    CFG_NUM_CHANNELS = 2'd2
  } cfg_idx_e;

  // One source pixel's worth of precomputed results
  typedef struct packed {
    logic signed [PIX_W-1:0] v_ul;   // row 2r-1, column 2c-1
    logic signed [PIX_W-1:0] v_u;    // row 2r-1, columns 2c and 2c+1
    logic signed [PIX_W-1:0] hl;     // rows 2r.., column 2c-1
    logic signed [PIX_W-1:0] cur;    // rows 2r.., columns 2c and 2c+1
    logic                    has_up;
    logic                    has_left;
    logic                    last_col;
    logic                    last_row;
    logic [CNT_W-1:0]        row;
    logic [CNT_W-1:0]        col;
    logic [CHAN_W-1:0]       chan;
  } item_t;

  // floor((a + b) / 2) on two signed 8-bit values
  function automatic logic signed [PIX_W-1:0] fmean(
    input logic signed [PIX_W-1:0] a,
    input logic signed [PIX_W-1:0] b
  );
    logic signed [PIX_W:0] sum;
    begin
      sum = {a[PIX_W-1], a} + {b[PIX_W-1], b};
      return sum[PIX_W:1];
    end
  endfunction

endpackage
`default_nettype wire

// ----- hdl/bu2x_emit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bu2x_emit: output sequencer of the 2x bilinear upscaler
// Walks the valid part of the 3x3 output neighborhood of one source pixel in
// raster order and pushes one result per cycle, unless the output stalls, through an output register.
// ----------------------------------------------------------------------------
module bu2x_emit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                item_valid_i,
  input  wire bu2x_pkg::item_t                     item_i,
  output logic                                     item_ready_o,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // value[7:0], out_channel[17:8], out_row[27:18], out_col[37:28], zero pad
  output logic [bu2x_pkg::OUT_DATA_W-1:0]          m_axis_tdata_o,
  output logic                                     m_axis_tlast_o
);

  bu2x_pkg::item_t item_q;
  logic            busy_q;
  logic [1:0]      ri_q, ci_q;
  logic            o_valid_q;
  logic [bu2x_pkg::OUT_DATA_W-1:0] o_data_q;
  logic            o_last_q;

  logic can_out, fire, col_end, row_end, is_last, load;
  logic signed [bu2x_pkg::PIX_W-1:0] val;
  logic [bu2x_pkg::COORD_W:0] row_full, col_full;

  // Step control
  assign can_out = !o_valid_q || m_axis_tready_i;
  assign fire    = busy_q && can_out;
  assign col_end = (ci_q == bu2x_pkg::POS_HI) ||
                   ((ci_q == bu2x_pkg::POS_MID) && !item_q.last_col);
  assign row_end = (ri_q == bu2x_pkg::POS_HI) ||
                   ((ri_q == bu2x_pkg::POS_MID) && !item_q.last_row);
  assign is_last = col_end && row_end;
  assign item_ready_o = !busy_q || (fire && is_last);
  assign load    = item_valid_i && item_ready_o;

  // Select the value of the current position
  always_comb begin
    if (ri_q == bu2x_pkg::POS_LO) begin
      val = (ci_q == bu2x_pkg::POS_LO) ? item_q.v_ul : item_q.v_u;
    end else begin
      val = (ci_q == bu2x_pkg::POS_LO) ? item_q.hl : item_q.cur;
    end
  end

  // Output coordinates: 2*index + position - 1
  assign row_full = {1'b0, item_q.row, 1'b0} + {9'd0, ri_q} - 11'd1;
  assign col_full = {1'b0, item_q.col, 1'b0} + {9'd0, ci_q} - 11'd1;

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ri_q   <= bu2x_pkg::POS_MID;
      ci_q   <= bu2x_pkg::POS_MID;
    end else if (load) begin
      busy_q <= 1'b1;
      ri_q   <= item_i.has_up   ? bu2x_pkg::POS_LO : bu2x_pkg::POS_MID;
      ci_q   <= item_i.has_left ? bu2x_pkg::POS_LO : bu2x_pkg::POS_MID;
    end else if (fire) begin
      if (is_last) begin
        busy_q <= 1'b0;
      end else if (col_end) begin
        ri_q <= ri_q + 2'd1;
        ci_q <= item_q.has_left ? bu2x_pkg::POS_LO : bu2x_pkg::POS_MID;
      end else begin
        ci_q <= ci_q + 2'd1;
      end
    end
  end

  // Hold the request being walked
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (fire) begin
      o_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      o_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      o_data_q <= {2'b00, col_full[bu2x_pkg::COORD_W-1:0],
                   row_full[bu2x_pkg::COORD_W-1:0], item_q.chan, val};
      o_last_q <= is_last;
    end
  end

  assign m_axis_tvalid_o = o_valid_q;
  assign m_axis_tdata_o  = o_data_q;
  assign m_axis_tlast_o  = o_last_q;

endmodule
`default_nettype wire

// ----- hdl/bilinear_upscale_2x_int8_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Path: the first result of a pixel passes the line-buffer read stage, the
//   emitter load and the output register before it leaves the block.
// Throughput: one result per cycle while the output is not stalled; a pixel
//   causes 1 to 9 results (4 inside the image), paced by the single result channel.
// Reset: counters, previous pixel and registers return to their reset values;
//   the line buffer is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
// bilinear_upscale_2x_int8_top: 2x bilinear upscaler for signed 8-bit planes
// Keeps the previous source row in a one-port synchronous line buffer, read
// and written back at the same column in the accept cycle, and hands each
// pixel's interpolated values to the output sequencer.
// ----------------------------------------------------------------------------
module bilinear_upscale_2x_int8_top #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [10:0] cfg_data_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // pixel[7:0]
  input  wire logic [7:0]  s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // value[7:0], out_channel[17:8], out_row[27:18], out_col[37:28], zero pad
  output logic [bu2x_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic             m_axis_tlast_o
);

  localparam int unsigned CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // Configuration registers
  logic [9:0]  src_width_q, src_height_q;
  logic [10:0] num_channels_q;

  // Position counters and previous pixel
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [bu2x_pkg::CHAN_W-1:0] chan_q;
  logic signed [7:0] prev_q;

  // Line buffer
  logic [7:0] line_mem [MAX_WIDTH];
  logic signed [7:0] rd_q;
  logic signed [7:0] aa_q;

  // Read stage
  logic              s1_valid_q;
  logic signed [7:0] s1_cur_q, s1_prv_q;
  logic              s1_has_up_q, s1_has_left_q, s1_last_col_q, s1_last_row_q;
  logic [CW-1:0]     s1_col_q;
  logic [RW-1:0]     s1_row_q;
  logic [bu2x_pkg::CHAN_W-1:0] s1_chan_q;

  logic [9:0]  w_m1, h_m1;
  logic [10:0] nc_m1;
  logic        last_col, last_row, last_chan;
  logic        in_fire, hand_off, item_ready;
  logic signed [7:0] pix, hl, v_u, v_ul;
  bu2x_pkg::item_t item;

  assign cfg_ready_o = 1'b1;
  assign pix = s_axis_tdata_i;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q    <= 10'd1;
      src_height_q   <= 10'd1;
      num_channels_q <= 11'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bu2x_pkg::CFG_SRC_WIDTH:    src_width_q    <= cfg_data_i[9:0];
        bu2x_pkg::CFG_SRC_HEIGHT:   src_height_q   <= cfg_data_i[9:0];
        bu2x_pkg::CFG_NUM_CHANNELS: num_channels_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp registers to their legal range, minus one
  always_comb begin
    if (src_width_q == 10'd0) begin
      w_m1 = 10'd0;
    end else if (src_width_q > 10'(MAX_WIDTH)) begin
      w_m1 = 10'(MAX_WIDTH - 1);
    end else begin
      w_m1 = src_width_q - 10'd1;
    end
    if (src_height_q == 10'd0) begin
      h_m1 = 10'd0;
    end else if (src_height_q > 10'(MAX_HEIGHT)) begin
      h_m1 = 10'(MAX_HEIGHT - 1);
    end else begin
      h_m1 = src_height_q - 10'd1;
    end
    if (num_channels_q == 11'd0) begin
      nc_m1 = 11'd0;
    end else if (num_channels_q > 11'd1024) begin
      nc_m1 = 11'd1023;
    end else begin
      nc_m1 = num_channels_q - 11'd1;
    end
  end

  assign last_col  = 10'(col_q) >= w_m1;
  assign last_row  = 10'(row_q) >= h_m1;
  assign last_chan = 11'(chan_q) >= nc_m1;

  // Input handshake
  assign hand_off        = s1_valid_q && item_ready;
  assign s_axis_tready_o = !s1_valid_q || item_ready;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // Advance position counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      chan_q <= '0;
      prev_q <= '0;
    end else if (in_fire) begin
      prev_q <= pix;
      if (last_col) begin
        col_q <= '0;
        if (last_row) begin
          row_q  <= '0;
          chan_q <= last_chan ? '0 : chan_q + 10'd1;
        end else begin
          row_q <= row_q + RW'(1);
        end
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // Read the upper neighbor and write back this row's pixel at the same column
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_q           <= line_mem[col_q];
      line_mem[col_q] <= pix;
    end
  end

  // Read stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (hand_off) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Read stage payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cur_q      <= pix;
      s1_prv_q      <= prev_q;
      s1_has_up_q   <= row_q != '0;
      s1_has_left_q <= col_q != '0;
      s1_last_col_q <= last_col;
      s1_last_row_q <= last_row;
      s1_col_q      <= col_q;
      s1_row_q      <= row_q;
      s1_chan_q     <= chan_q;
    end
  end

  // Keep the upper neighbor of the previous column
  always_ff @(posedge clk_i) begin
    if (hand_off) begin
      aa_q <= rd_q;
    end
  end

  // Interpolate
  assign hl   = bu2x_pkg::fmean(s1_prv_q, s1_cur_q);
  assign v_u  = bu2x_pkg::fmean(rd_q, s1_cur_q);
  assign v_ul = bu2x_pkg::fmean(bu2x_pkg::fmean(aa_q, rd_q), hl);

  always_comb begin
    item.v_ul     = v_ul;
    item.v_u      = v_u;
    item.hl       = hl;
    item.cur      = s1_cur_q;
    item.has_up   = s1_has_up_q;
    item.has_left = s1_has_left_q;
    item.last_col = s1_last_col_q;
    item.last_row = s1_last_row_q;
    item.row      = bu2x_pkg::CNT_W'(s1_row_q);
    item.col      = bu2x_pkg::CNT_W'(s1_col_q);
    item.chan     = s1_chan_q;
  end

  bu2x_emit u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (s1_valid_q),
    .item_i          (item),
    .item_ready_o    (item_ready),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Checks
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> s1_valid_q)
    else $error("input stalled with empty read stage");

  a_col_in_buffer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    10'(col_q) <= 10'(MAX_WIDTH - 1))
    else $error("column counter beyond line buffer");

  a_hand_off_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hand_off && !in_fire) |=> !s1_valid_q)
    else $error("read stage kept a request already handed off");

  a_counters_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !last_col) |=> (col_q == $past(col_q) + CW'(1)))
    else $error("column counter did not advance");

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the 2x bilinear int8 upscaler
// Streams signed source pixels through several image geometries, including
// out-of-range register values and geometry changes in the middle of an
// image. A cycle-free predictor tracks the line buffer and the counters and
// queues every interpolated output pixel. Each output request is checked
// field by field against the oldest queued pixel. Random bursts on the input
// side and a changing stall pattern on the output side shape the traffic.
// ----------------------------------------------------------------------------
module tb;

  // One expected output pixel
  typedef struct packed {
    logic [7:0] value;
    logic [9:0] chan;
    logic [9:0] row;
    logic [9:0] col;
    logic       last;
  } out_pix_t;

  // Predictor of the upscaler: line buffer, counters, registers and the
  // queue of output pixels still to come
  class upscale_tracker;
    logic [7:0]  line_mem [512];
    logic [7:0]  left_px;
    int unsigned col, row, chan;
    int unsigned width_reg, height_reg, chans_reg;
    out_pix_t    interp_q [$];
    int unsigned n_bad;

    function new();
      foreach (line_mem[i]) line_mem[i] = '0;
      left_px    = '0;
      col        = 0;
      row        = 0;
      chan       = 0;
      width_reg  = 1;
      height_reg = 1;
      chans_reg  = 1;
      n_bad      = 0;
    endfunction

    // A zero register acts as 1, a value above the limit as the limit
    function int unsigned clip(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(bu2x_pkg::cfg_idx_e idx, logic [10:0] val);
      case (idx)
        bu2x_pkg::CFG_SRC_WIDTH:    width_reg  = val[9:0];
        bu2x_pkg::CFG_SRC_HEIGHT:   height_reg = val[9:0];
        bu2x_pkg::CFG_NUM_CHANNELS: chans_reg  = val;
        default: ;
      endcase
    endfunction

    // floor((a + b) / 2)
    function logic signed [7:0] half_sum(logic signed [7:0] a, logic signed [7:0] b);
      int s;
      s = int'(a) + int'(b);
      return 8'(s >>> 1);
    endfunction

    function void queue_out(logic [7:0] v, int unsigned orow, int unsigned ocol);
      out_pix_t p;
      p.value = v;
      p.chan  = 10'(chan);
      p.row   = 10'(orow);
      p.col   = 10'(ocol);
      p.last  = 1'b0;
      interp_q.push_back(p);
    endfunction

    // Work out every output pixel that becomes complete with this source pixel
    function void take_pixel(logic [7:0] px);
      int unsigned       w, h, nc, orow, n_pass;
      bit                end_col, end_row;
      logic signed [7:0] cur, up_here, up_left, h_left;
      w       = clip(width_reg, 512);
      h       = clip(height_reg, 512);
      nc      = clip(chans_reg, 1024);
      end_col = col >= w - 1;
      end_row = row >= h - 1;
      cur     = px;
      up_here = line_mem[col];
      up_left = (col >= 1) ? line_mem[col - 1] : '0;
      h_left  = (col >= 1) ? half_sum(left_px, cur) : '0;

      // odd row above, blended with the buffered row
      if (row >= 1) begin
        orow = 2 * row - 1;
        if (col >= 1) queue_out(half_sum(half_sum(up_left, up_here), h_left), orow, 2 * col - 1);
        queue_out(half_sum(up_here, cur), orow, 2 * col);
        if (end_col) queue_out(half_sum(up_here, cur), orow, 2 * col + 1);
      end
      // even row, repeated below the last source row
      n_pass = end_row ? 2 : 1;
      for (int p = 0; p < n_pass; p++) begin
        orow = 2 * row + p;
        if (col >= 1) queue_out(h_left, orow, 2 * col - 1);
        queue_out(cur, orow, 2 * col);
        if (end_col) queue_out(cur, orow, 2 * col + 1);
      end
      interp_q[interp_q.size() - 1].last = 1'b1;

      // line buffer takes the current row behind the read position
      if (col >= 1) line_mem[col - 1] = left_px;
      if (end_col) line_mem[col] = px;
      left_px = px;

      // advance column, row, channel
      if (end_col) begin
        col = 0;
        if (end_row) begin
          row  = 0;
          chan = (chan >= nc - 1) ? 0 : chan + 1;
        end else begin
          row = row + 1;
        end
      end else begin
        col = col + 1;
      end
    endfunction

    function void note_bad(string msg);
      n_bad++;
      if (n_bad <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void cmp(string name, out_pix_t want, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v)
        note_bad($sformatf("%s expected %0d got %0d (ch %0d row %0d col %0d)",
                           name, exp_v, got_v, want.chan, want.row, want.col));
    endfunction

    // Compare one accepted output request with the oldest queued pixel
    function void match_output(logic [39:0] data, logic lst);
      out_pix_t want;
      if (interp_q.size() == 0) begin
        note_bad($sformatf("unexpected output data=%h last=%b", data, lst));
        return;
      end
      want = interp_q.pop_front();
      cmp("value", want, want.value, data[7:0]);
      cmp("channel", want, want.chan, data[17:8]);
      cmp("row", want, want.row, data[27:18]);
      cmp("column", want, want.col, data[37:28]);
      cmp("pad", want, 0, data[39:38]);
      cmp("last", want, want.last, lst);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [bu2x_pkg::OUT_DATA_W-1:0] m_tdata;
  logic        m_tlast;

  upscale_tracker tracker;
  int unsigned    px_sent = 0;
  int unsigned    burst_left = 0;
  logic [7:0]     stall_mask = 8'hFF;
  int unsigned    mask_left = 0;
  logic [2:0]     stall_phase = '0;

  bilinear_upscale_2x_int8_top u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop for a hung handshake
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Write the selected registers, one request each, then drop valid
  task automatic set_config(input logic [10:0] w, input logic [10:0] h,
                            input logic [10:0] nc, input bit [2:0] sel);
    logic [10:0] vals [3];
    bit          took;
    vals = '{w, h, nc};
    for (int i = 0; i < 3; i++) begin
      if (sel[i]) begin
        cfg_valid <= 1'b1;
        cfg_index <= bu2x_pkg::cfg_idx_e'(i);
        cfg_data  <= vals[i];
        do begin
          @(negedge clk);
          took = cfg_ready;
          @(posedge clk);
        end while (!took);
        tracker.write_reg(bu2x_pkg::cfg_idx_e'(i), vals[i]);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  // Offer one pixel; after the request goes through, maybe open a gap
  task automatic send_pixel(input logic [7:0] px);
    bit          took;
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    do begin
      @(negedge clk);
      took = s_tready;
      @(posedge clk);
    end while (!took);
    tracker.take_pixel(px);
    px_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      case ($urandom_range(0, 7))
        0:       gap = $urandom_range(8, 20);
        1, 2, 3: gap = 0;
        default: gap = $urandom_range(1, 4);
      endcase
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop offering pixels and hold until every queued output has arrived
  task automatic drain();
    s_tvalid <= 1'b0;
    while (tracker.interp_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_px();
    case ($urandom_range(0, 9))
      0:       return 8'h7F;
      1:       return 8'h80;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Output side: sample before the edge, check at the edge, stall on a mask
  initial begin
    bit         fire;
    logic [39:0] out_data;
    logic       out_last;
    forever begin
      @(negedge clk);
      fire     = m_tvalid && m_tready;
      out_data = m_tdata;
      out_last = m_tlast;
      @(posedge clk);
      if (fire) tracker.match_output(out_data, out_last);
      if (mask_left == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_mask = 8'hFF;
          1:       stall_mask = 8'h11;
          default: stall_mask = 8'($urandom) | 8'h08;
        endcase
        mask_left = $urandom_range(16, 80);
      end
      mask_left--;
      stall_phase++;
      m_tready <= stall_mask[stall_phase];
    end
  end

  initial begin
    logic [10:0] nw, nh, nn;
    bit [2:0]    sel;
    int unsigned size, cnt;
    logic [7:0]  edge_px [9];

    tracker = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry: 1x1, one channel
    send_pixel(8'h7F);
    send_pixel(8'h80);
    drain();

    // 3x3 of extreme values to stress rounding of the means
    edge_px = '{8'h7F, 8'h80, 8'h7F, 8'h80, 8'h7F, 8'h80, 8'hFF, 8'h00, 8'hFF};
    set_config(11'd3, 11'd3, 11'd1, 3'b111);
    foreach (edge_px[i]) send_pixel(edge_px[i]);
    drain();

    // zero width and zero channels act as 1
    set_config(11'd0, 11'd2, 11'd0, 3'b111);
    send_pixel(8'h80);
    send_pixel(8'h7F);
    drain();

    // two channels of a single row
    set_config(11'd2, 11'd1, 11'd2, 3'b111);
    repeat (4) send_pixel(rand_px());
    drain();

    // registers above their limits, then shrink width and height mid-image
    set_config(11'd1023, 11'd1023, 11'd2047, 3'b111);
    repeat (6) send_pixel(rand_px());
    drain();
    set_config(11'd2, 11'd0, 11'd0, 3'b001);
    repeat (3) send_pixel(rand_px());
    drain();
    set_config(11'd0, 11'd2, 11'd0, 3'b010);
    repeat (2) send_pixel(rand_px());
    drain();

    // random geometries: mostly whole small images, some cut short
    while (px_sent < 360) begin
      case ($urandom_range(0, 24))
        0:       nw = 11'd0;
        1, 2:    nw = 11'd512;
        3, 4:    nw = 11'($urandom_range(513, 1023));
        5, 6:    nw = 11'($urandom_range(9, 40));
        default: nw = 11'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 24))
        0:       nh = 11'd0;
        1, 2:    nh = 11'd512;
        3, 4:    nh = 11'($urandom_range(513, 1023));
        5, 6:    nh = 11'($urandom_range(7, 20));
        default: nh = 11'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 19))
        0:          nn = 11'd0;
        1, 2:       nn = 11'd1024;
        3, 4:       nn = 11'($urandom_range(1025, 2047));
        5, 6, 7:    nn = 11'($urandom_range(4, 8));
        default:    nn = 11'($urandom_range(1, 3));
      endcase
      sel = 3'($urandom);
      // past the first row the line buffer holds only the old width
      if (tracker.row != 0 &&
          tracker.clip(nw[9:0], 512) > tracker.clip(tracker.width_reg, 512))
        sel[0] = 1'b0;
      set_config(nw, nh, nn, sel);

      size = tracker.clip(tracker.width_reg, 512) * tracker.clip(tracker.height_reg, 512);
      if (size <= 48) cnt = size * $urandom_range(1, 3);
      else cnt = $urandom_range(1, 40);
      repeat (cnt) send_pixel(rand_px());
      drain();
    end

    // let any stray output show up before the verdict
    repeat (20) @(posedge clk);
    if (tracker.n_bad == 0 && tracker.interp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/bu2x_pkg.sv
hdl/bu2x_emit.sv
hdl/bilinear_upscale_2x_int8_top.sv
tb/tb.sv
